### rtl/seven_segment_mux_display_assert.svh
// Assertion macros for the seven-segment display driver.
`ifndef SEVEN_SEGMENT_MUX_DISPLAY_ASSERT_SVH
`define SEVEN_SEGMENT_MUX_DISPLAY_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at each rising clock edge outside reset.
`define SSD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("seven segment display: same-cycle check failed");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define SSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("seven segment display: next-cycle check failed");

`else

`define SSD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/ssd_pkg.sv
// Package with the item types, command codes and glyph table of the display driver.
package ssd_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int SCAN_W      = $clog2(DIGIT_COUNT);

   localparam logic [2:0] CMD_SCAN  = 3'd0;
   localparam logic [2:0] CMD_DEC   = 3'd1;
   localparam logic [2:0] CMD_HEX   = 3'd2;
   localparam logic [2:0] CMD_LOAD  = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;

   localparam logic [7:0]  CODE_BLANK = 8'hFF;
   localparam logic [7:0]  CODE_DASH  = 8'hBF;
   localparam logic [15:0] DEC_LIMIT  = 16'd9999;

   // Active-low glyphs for 0..F.
   localparam logic [7:0] GLYPHS [16] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
      8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
   };

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] number;
      logic [1:0]  position;
      logic [7:0]  seg_code;
      logic [7:0]  buf_len;
   } ssd_req_type;

   typedef struct packed {
      logic [7:0]             segments;
      logic [DIGIT_COUNT-1:0] digit_enable_n;
   } ssd_rsp_type;

endpackage

### rtl/seven_segment_mux_display.sv
// Four-digit multiplexed seven-segment display driver, top level.
//
// Input channel (req_valid/req_ready/req_data) takes commands: scan tick,
// show decimal, show hex, load one entry, clear. Result channel
// (rsp_valid/rsp_ready/rsp_data) returns the segment and digit-enable port
// values for each scan tick and each clear; other commands give no result.
// An accepted item is registered in the input register, executed against the
// digit buffer when it leaves that register, and its result is registered in
// the output register. Unless a stall holds the input register,
// one item is accepted per clock. The decimal divisions by 1000, 100 and 10
// are reciprocal multiplies done ahead of the input register, so the
// execute step is only subtracts, a compare and the glyph table.
// When the receiver stalls, results wait in the output register; the input
// register holds the next item and stops only if that item also makes a
// result. Commands without a result keep flowing during a stall.
// Synchronous reset blanks all four digits, sets the scan index to digit 0
// and empties both registers; the block accepts items right after reset.
`include "seven_segment_mux_display_assert.svh"

module seven_segment_mux_display (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ssd_pkg::ssd_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ssd_pkg::ssd_rsp_type rsp_data
);
   import ssd_pkg::*;

   // Reciprocals, exact for numbers up to 9999.
   localparam logic [13:0] RECIP_1000 = 14'd8389;  // 2^23 / 1000
   localparam logic [12:0] RECIP_100  = 13'd5243;  // 2^19 / 100
   localparam logic [12:0] RECIP_10   = 13'd6554;  // 2^16 / 10

   ssd_req_type stg_req_ff;
   logic        stg_valid_ff, stg_valid_in;
   logic [3:0]  stg_q1000_ff, stg_q1000_in;
   logic [6:0]  stg_q100_ff, stg_q100_in;
   logic [9:0]  stg_q10_ff, stg_q10_in;
   logic [29:0] prod_1000;
   logic [28:0] prod_100;
   logic [28:0] prod_10;

   logic [7:0]        codes_ff [DIGIT_COUNT];
   logic [7:0]        codes_in [DIGIT_COUNT];
   logic [SCAN_W-1:0] scan_ff, scan_in;

   logic        rsp_valid_ff, rsp_valid_in;
   ssd_rsp_type rsp_data_ff, rsp_data_in;

   logic        stg_has_rsp, stg_fire, req_take;
   logic [6:0]  rem_100;
   logic [9:0]  rem_10;
   logic [15:0] rem_1;
   logic [3:0]  dec_digit [DIGIT_COUNT];
   logic [7:0]  dec_codes [DIGIT_COUNT];
   logic [7:0]  scan_code;

   // Handshake and pipeline control.
   assign stg_has_rsp = (stg_req_ff.cmd == CMD_SCAN) || (stg_req_ff.cmd == CMD_CLEAR);
   assign stg_fire    = stg_valid_ff && (!stg_has_rsp || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !stg_valid_ff || stg_fire;
   assign req_take    = req_valid && req_ready;
   assign stg_valid_in = req_ready ? req_valid : stg_valid_ff;

   // Quotients are formed before the input register.
   assign prod_1000    = req_data.number * RECIP_1000;
   assign prod_100     = req_data.number * RECIP_100;
   assign prod_10      = req_data.number * RECIP_10;
   assign stg_q1000_in = prod_1000[26:23];
   assign stg_q100_in  = prod_100[25:19];
   assign stg_q10_in   = prod_10[25:16];

   // Decimal digits from the quotients; only meaningful up to 9999.
   assign rem_100 = stg_q100_ff - (({3'b000, stg_q1000_ff} << 3) + ({3'b000, stg_q1000_ff} << 1));
   assign rem_10  = stg_q10_ff - (({3'b000, stg_q100_ff} << 3) + ({3'b000, stg_q100_ff} << 1));
   assign rem_1   = stg_req_ff.number - (({6'b0, stg_q10_ff} << 3) + ({6'b0, stg_q10_ff} << 1));

   always_comb begin
      dec_digit[0] = stg_q1000_ff;
      dec_digit[1] = rem_100[3:0];
      dec_digit[2] = rem_10[3:0];
      dec_digit[3] = rem_1[3:0];
      if (stg_req_ff.number > DEC_LIMIT) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            dec_codes[i] = CODE_DASH;
         end
      end else begin
         // Leading zeros blank; the last digit always shows.
         dec_codes[0] = (dec_digit[0] == 4'd0) ? CODE_BLANK : GLYPHS[dec_digit[0]];
         dec_codes[1] = (dec_digit[0] == 4'd0 && dec_digit[1] == 4'd0) ?
                        CODE_BLANK : GLYPHS[dec_digit[1]];
         dec_codes[2] = (dec_digit[0] == 4'd0 && dec_digit[1] == 4'd0 &&
                         dec_digit[2] == 4'd0) ? CODE_BLANK : GLYPHS[dec_digit[2]];
         dec_codes[3] = GLYPHS[dec_digit[3]];
      end
   end

   assign scan_code = codes_ff[scan_ff];

   // Execute step: buffer update, scan advance and result formation.
   always_comb begin
      codes_in    = codes_ff;
      scan_in     = scan_ff;
      rsp_data_in = rsp_data_ff;
      if (stg_fire) begin
         unique case (stg_req_ff.cmd)
            CMD_SCAN: begin
               if (scan_code != CODE_BLANK) begin
                  rsp_data_in.segments       = scan_code;
                  rsp_data_in.digit_enable_n =
                     ~({{(DIGIT_COUNT-1){1'b0}}, 1'b1} << scan_ff);
               end else begin
                  rsp_data_in.segments       = CODE_BLANK;
                  rsp_data_in.digit_enable_n = '1;
               end
               scan_in = scan_ff + 1'b1;
            end
            CMD_DEC: begin
               codes_in = dec_codes;
            end
            CMD_HEX: begin
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  codes_in[i] = GLYPHS[stg_req_ff.number[(DIGIT_COUNT-1-i)*4 +: 4]];
               end
            end
            CMD_LOAD: begin
               codes_in[stg_req_ff.position] =
                  ({6'b0, stg_req_ff.position} < stg_req_ff.buf_len) ?
                  stg_req_ff.seg_code : CODE_BLANK;
            end
            CMD_CLEAR: begin
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  codes_in[i] = CODE_BLANK;
               end
               scan_in = '0;
               rsp_data_in.segments       = CODE_BLANK;
               rsp_data_in.digit_enable_n = '1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (stg_fire && stg_has_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            codes_ff[i] <= CODE_BLANK;
         end
      end else begin
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         codes_ff     <= codes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_req_ff   <= req_data;
         stg_q1000_ff <= stg_q1000_in;
         stg_q100_ff  <= stg_q100_in;
         stg_q10_ff   <= stg_q10_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A lit digit is always exactly one enable; an unlit port shows no segments.
   `SSD_ASSERT_SAME(a_one_digit, clock, reset,
      rsp_valid_ff && (rsp_data_ff.digit_enable_n != '1), $onehot(~rsp_data_ff.digit_enable_n))
   `SSD_ASSERT_SAME(a_dark_port, clock, reset,
      rsp_valid_ff && (rsp_data_ff.digit_enable_n == '1), rsp_data_ff.segments == CODE_BLANK)
   `SSD_ASSERT_NEXT(a_clear_scan, clock, reset,
      stg_fire && (stg_req_ff.cmd == CMD_CLEAR), scan_ff == '0)

endmodule

### tb/sv/tb_seven_segment_mux_display.sv
// Self-checking testbench for the four-digit multiplexed seven-segment display driver.
module tb_seven_segment_mux_display;
   timeunit 1ns;
   timeprecision 1ps;

   import ssd_pkg::*;

   localparam int         CYCLE_LIMIT      = 200000;
   localparam int         DRAIN_SLACK      = 8;
   localparam int         REPORT_LIMIT     = 50;
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
   localparam logic [7:0] BLANK_GLYPH      = 8'hFF;
   localparam logic [7:0] DASH_GLYPH       = 8'hBF;
   localparam logic [3:0] ALL_DIGITS_OFF   = 4'hF;
   localparam int         DECIMAL_MAX      = 9999;

   // Active-low segment patterns for 0..F.
   localparam logic [7:0] SEG_FONT [16] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
      8'h80, 8'h90, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
   };

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ssd_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ssd_rsp_type rsp_data;

   // Shadow of the display buffer and scan index.
   logic [7:0]  digit_buf [DIGIT_COUNT] = '{default: 8'hFF};
   logic [1:0]  scan_idx = '0;

   ssd_rsp_type expected_frames [$];
   int          error_count  = 0;
   int          cycle_count  = 0;
   int          issued_items = 0;
   bit          full_rate    = 1'b0;

   seven_segment_mux_display dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_seven_segment_mux_display failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%0t ns mismatch: %s", $realtime, what);
      end
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (full_rate || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Applies one accepted item to the shadow buffer and queues the port value it yields.
   function automatic void predict_item(input ssd_req_type item);
      logic [3:0]  dec_digit [4];
      ssd_rsp_type frame;
      bit          leading;
      int          value;
      value = int'(item.number);
      case (item.cmd)
         CMD_SCAN: begin
            frame.segments = digit_buf[scan_idx];
            frame.digit_enable_n = (digit_buf[scan_idx] == BLANK_GLYPH) ?
                                   ALL_DIGITS_OFF : ~(4'b0001 << scan_idx);
            scan_idx = scan_idx + 2'd1;
            expected_frames.push_back(frame);
         end
         CMD_DEC: begin
            if (value > DECIMAL_MAX) begin
               for (int i = 0; i < DIGIT_COUNT; i++) digit_buf[i] = DASH_GLYPH;
            end else begin
               dec_digit[0] = 4'(value / 1000);
               dec_digit[1] = 4'((value / 100) % 10);
               dec_digit[2] = 4'((value / 10) % 10);
               dec_digit[3] = 4'(value % 10);
               leading = 1'b1;
               // Zeros ahead of the first nonzero digit go dark; the units digit always shows.
               for (int i = 0; i < DIGIT_COUNT; i++) begin
                  if (i != DIGIT_COUNT - 1 && leading && dec_digit[i] == 4'd0) begin
                     digit_buf[i] = BLANK_GLYPH;
                  end else begin
                     leading = 1'b0;
                     digit_buf[i] = SEG_FONT[dec_digit[i]];
                  end
               end
            end
         end
         CMD_HEX: begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               digit_buf[i] = SEG_FONT[item.number[15 - 4 * i -: 4]];
            end
         end
         CMD_LOAD: begin
            digit_buf[item.position] = (item.position < item.buf_len) ?
                                       item.seg_code : BLANK_GLYPH;
         end
         CMD_CLEAR: begin
            for (int i = 0; i < DIGIT_COUNT; i++) digit_buf[i] = BLANK_GLYPH;
            scan_idx = '0;
            frame.segments = BLANK_GLYPH;
            frame.digit_enable_n = ALL_DIGITS_OFF;
            expected_frames.push_back(frame);
         end
         default: ;
      endcase
   endfunction

   // Call at a rising edge; returns at the edge where the item is accepted.
   task automatic send_item(input logic [2:0] cmd, input logic [15:0] number,
                            input logic [1:0] position, input logic [7:0] seg_code,
                            input logic [7:0] buf_len);
      ssd_req_type item;
      int          gap;
      item.cmd      = cmd;
      item.number   = number;
      item.position = position;
      item.seg_code = seg_code;
      item.buf_len  = buf_len;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_item(item);
      if (cmd < CMD_UNUSED_FIRST) issued_items++;
   endtask

   task automatic send_scans(input int count);
      repeat (count) send_item(CMD_SCAN, 16'($urandom), 2'($urandom), 8'($urandom),
                               8'($urandom));
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_frames.size() != 0);
   endtask

   // Receiver: bursts of readiness broken by stalls, none while running at full rate.
   initial begin
      int run;
      int stall;
      forever begin
         if (full_rate) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            run = $urandom_range(1, 20);
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clock);
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      ssd_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected result segments %h enables %h",
                                      rsp_data.segments, rsp_data.digit_enable_n));
         end else begin
            want = expected_frames.pop_front();
            if (rsp_data.segments !== want.segments) begin
               report_mismatch($sformatf("segments %h, expected %h",
                                         rsp_data.segments, want.segments));
            end
            if (rsp_data.digit_enable_n !== want.digit_enable_n) begin
               report_mismatch($sformatf("digit enables %h, expected %h",
                                         rsp_data.digit_enable_n, want.digit_enable_n));
            end
         end
      end
   end

   function automatic logic [15:0] pick_number();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom_range(0, 9));
         1:       return 16'($urandom_range(0, 99));
         2:       return 16'($urandom_range(0, 999));
         3:       return 16'($urandom_range(0, DECIMAL_MAX));
         4:       return 16'($urandom_range(DECIMAL_MAX - 9, DECIMAL_MAX + 11));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic test_blank_after_reset();
      send_scans(1);
   endtask

   task automatic test_decimal_display();
      send_item(CMD_DEC, 16'd0, 2'($urandom), 8'($urandom), 8'($urandom));
      send_scans(3);
      send_item(CMD_DEC, 16'd9999, 2'($urandom), 8'($urandom), 8'($urandom));
      send_scans(1);
      send_item(CMD_DEC, 16'd10000, 2'($urandom), 8'($urandom), 8'($urandom));
      send_scans(1);
      send_item(CMD_DEC, 16'hFFFF, 2'($urandom), 8'($urandom), 8'($urandom));
      send_item(CMD_DEC, 16'd1005, 2'($urandom), 8'($urandom), 8'($urandom));
      send_scans(2);
   endtask

   task automatic test_hex_display();
      send_item(CMD_HEX, 16'hFFFF, 2'($urandom), 8'($urandom), 8'($urandom));
      send_scans(1);
      send_item(CMD_HEX, 16'h0000, 2'($urandom), 8'($urandom), 8'($urandom));
      send_scans(1);
   endtask

   task automatic test_load_entries();
      send_item(CMD_LOAD, 16'($urandom), 2'd3, 8'h00, 8'hFF);
      send_item(CMD_LOAD, 16'($urandom), 2'd0, 8'h55, 8'h00);
      send_item(CMD_LOAD, 16'($urandom), 2'd2, 8'hAA, 8'h02);
      send_item(CMD_LOAD, 16'($urandom), 2'd1, 8'h12, 8'h02);
      send_scans(2);
   endtask

   task automatic test_ignored_and_clear();
      for (logic [3:0] c = 4'(CMD_UNUSED_FIRST); c <= 4'(CMD_UNUSED_LAST); c++) begin
         send_item(c[2:0], 16'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
      end
      send_item(CMD_CLEAR, 16'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
      send_scans(1);
   endtask

   // Mostly an update followed by a run of scan ticks, with stray and ignored items mixed in.
   task automatic test_random_traffic(input int target);
      int goal;
      int pick;
      goal = issued_items + target;
      while (issued_items < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_item(CMD_DEC, pick_number(), 2'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 55) begin
            send_item(CMD_HEX, 16'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) begin
               send_item(CMD_LOAD, 16'($urandom), 2'($urandom),
                         ($urandom_range(0, 7) == 0) ? BLANK_GLYPH : 8'($urandom),
                         $urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom));
            end
         end else if (pick < 88) begin
            send_item(CMD_CLEAR, 16'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
         end else if (pick < 94) begin
            send_item(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                      16'($urandom), 2'($urandom), 8'($urandom), 8'($urandom));
         end
         send_scans($urandom_range(0, 8));
      end
   endtask

   task automatic test_full_rate();
      full_rate = 1'b1;
      test_random_traffic(60);
      full_rate = 1'b0;
   endtask

   task automatic test_drain_pauses();
      repeat (3) begin
         test_random_traffic(20);
         wait_for_drain();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_blank_after_reset();
      test_decimal_display();
      test_hex_display();
      test_load_entries();
      test_ignored_and_clear();
      test_random_traffic(150);
      test_full_rate();
      test_drain_pauses();
      test_random_traffic(150);
      wait_for_drain();
      repeat (DRAIN_SLACK) @(posedge clock);
      if (expected_frames.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_frames.size()));
      end
      if (error_count == 0) begin
         $display("tb_seven_segment_mux_display passed");
      end else begin
         $display("tb_seven_segment_mux_display failed");
      end
      $finish;
   end

endmodule
